/* src/aes128_block_encrypt_assert.svh */
// ------------------------------------------------------------------------
// AES-128 block encrypt assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ------------------------------------------------------------------------
`ifndef AES128_BLOCK_ENCRYPT_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AES_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/aes_pkg.sv */
// ------------------------------------------------------------------------
// AES-128 package
// Types, tables and round functions for the AES-128 encryption pipeline.
// ------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned MaxRounds = 10;

  typedef logic [127:0] blk_t;
  typedef logic [3:0]   rnd_t;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH    = 2'd0,
    CFG_KEY_LOW     = 2'd1,
    CFG_ROUND_COUNT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [MaxRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  localparam logic [8:0] GfPoly = 9'h11b;
  localparam logic [7:0] GfTop  = 8'h80;

  // Block byte n sits in bits 127-8n down to 120-8n.
  function automatic logic [7:0] get_byte(input blk_t v, input int unsigned n);
    return v[127 - 8*n -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    logic [8:0] v;
    v = {b, 1'b0};
    if ((b & GfTop) != 8'h00) v = v ^ GfPoly;
    return v[7:0];
  endfunction

  function automatic blk_t next_round_key(input blk_t k, input logic [7:0] rc);
    logic [7:0] kb [16];
    logic [7:0] w  [4];
    blk_t       res;
    for (int i = 0; i < 16; i++) kb[i] = get_byte(k, i);
    for (int i = 0; i < 4; i++) w[i] = SBOX[kb[12 + ((i + 1) % 4)]];
    w[0] = w[0] ^ rc;
    for (int i = 0; i < 4; i++) kb[i] = kb[i] ^ w[i];
    for (int i = 4; i < 16; i++) kb[i] = kb[i] ^ kb[i-4];
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = kb[i];
    return res;
  endfunction

  // One cipher round on the state; MixColumns is left out on the final round.
  function automatic blk_t cipher_round(input blk_t s, input blk_t rk, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    blk_t       res;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[r + 4*c] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0  = t[4*c];
        a1  = t[4*c+1];
        a2  = t[4*c+2];
        a3  = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = t[i];
    return res ^ rk;
  endfunction

endpackage

/* src/aes128_block_encrypt.sv */
// ------------------------------------------------------------------------
// AES-128 block encrypt
// Fully unrolled AES-128 encryption pipeline with 1 to 10 rounds.
// ------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   input     in_valid / in_stall     block_high, block_low
//   output    out_valid / out_stall   cipher_high, cipher_low
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A block passes 11 register stages: the first adds the cipher key, and
// each of the next ten performs one round. One block may enter every cycle
// while the first stage has room; the round stage, one S-box layer plus the
// key-schedule step that rides along with the data, sets the clock period.
// Stages past the configured round count pass the state through unchanged.
// Reset (rst, synchronous) empties the pipeline and loads a zero key and a
// round count of 10. A stall on the output holds the last stage; earlier
// stages keep filling any empty slots, so bubbles are squeezed out.
//
module aes128_block_encrypt
  import aes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

`include "aes128_block_encrypt_assert.svh"

  localparam int unsigned NumStages = MaxRounds + 1;

  // Configuration registers.
  logic [63:0] key_high;
  logic [63:0] key_low;
  rnd_t        round_count;
  rnd_t        rounds;

  // Pipeline registers: state, round key and a valid bit per stage.
  blk_t                 stage_state [NumStages];
  blk_t                 stage_key   [NumStages];
  logic [NumStages-1:0] stage_valid;
  logic [NumStages:0]   stage_ready;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high    <= '0;
      key_low     <= '0;
      round_count <= 4'(MaxRounds);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY_HIGH:    key_high    <= cfg_data;
        CFG_KEY_LOW:     key_low     <= cfg_data;
        CFG_ROUND_COUNT: round_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // A round count of zero acts as one, and counts above ten act as ten.
  always_comb begin
    if (round_count == 4'd0) begin
      rounds = 4'd1;
    end else if (round_count > 4'(MaxRounds)) begin
      rounds = 4'(MaxRounds);
    end else begin
      rounds = round_count;
    end
  end

  // A stage can take a new item when it is empty or its item moves on.
  always_comb begin
    stage_ready[NumStages] = !out_stall;
    for (int i = NumStages - 1; i >= 0; i--) begin
      stage_ready[i] = !stage_valid[i] || stage_ready[i+1];
    end
  end

  assign in_stall = !stage_ready[0];

  // Initial key addition.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else if (stage_ready[0]) begin
      stage_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready[0] && in_valid) begin
      stage_state[0] <= {block_high, block_low} ^ {key_high, key_low};
      stage_key[0]   <= {key_high, key_low};
    end
  end

  // Round stages; stage i performs round i-1 when that round is in use.
  for (genvar g = 1; g < NumStages; g++) begin : g_round
    localparam rnd_t RoundIdx = rnd_t'(g - 1);
    logic active;
    logic last;
    blk_t key_next;

    assign active   = RoundIdx < rounds;
    assign last     = (RoundIdx + 4'd1) == rounds;
    assign key_next = next_round_key(stage_key[g-1], RCON[g-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[g] <= 1'b0;
      end else if (stage_ready[g]) begin
        stage_valid[g] <= stage_valid[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (stage_ready[g] && stage_valid[g-1]) begin
        if (active) begin
          stage_state[g] <= cipher_round(stage_state[g-1], key_next, last);
          stage_key[g]   <= key_next;
        end else begin
          stage_state[g] <= stage_state[g-1];
          stage_key[g]   <= stage_key[g-1];
        end
      end
    end
  end

  assign out_valid   = stage_valid[NumStages-1];
  assign cipher_high = stage_state[NumStages-1][127:64];
  assign cipher_low  = stage_state[NumStages-1][63:0];

  // Input back-pressure only arises when every stage is full and the output stalls.
  `AES_ASSERT_SAME(a_stall_full, in_stall, (&stage_valid) && out_stall,
    "input stalled while the pipeline has room")
  // An accepted transfer always lands in the first stage.
  `AES_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, stage_valid[0],
    "accepted block missing from the first stage")
  // A held item in stalled round stage 5 is never dropped.
  `AES_ASSERT_NEXT(a_hold_mid, stage_valid[5] && !stage_ready[6], stage_valid[5],
    "stalled block lost from a round stage")
  // The effective round count always stays in range.
  `AES_ASSERT_SAME(a_rounds_range, 1'b1, rounds >= 4'd1 && rounds <= 4'(MaxRounds),
    "effective round count out of range")

endmodule

/* bench/tb_aes128_block_encrypt.sv */
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// AES-128 block encrypt testbench
// Drives plaintext blocks through the cipher pipeline under several keys
// and round counts, and checks every ciphertext against a local model.
// ------------------------------------------------------------------------
module tb_aes128_block_encrypt;
  import aes_pkg::*;

  // Clock, reset and the three channels of the block.
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  aes128_block_encrypt DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .block_high(block_high), .block_low(block_low),
    .out_valid(out_valid), .out_stall(out_stall),
    .cipher_high(cipher_high), .cipher_low(cipher_low),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int PipeDepth  = 11;
  localparam int CycleLimit = 400000;

  // Our own copy of the configuration registers.
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic [3:0]  rounds_q;

  // Ciphertexts still owed by the block, oldest first.
  logic [127:0] cipher_queue [$];

  int  mismatches;
  int  blocks_sent;
  int  ciphers_seen;
  int  cycle_count;
  int  hold_off_cycles;
  bit  burst_mode;

  // Standard S-box, copied here so the prediction stands on its own.
  logic [7:0] sub_table [256];
  logic [7:0] round_const [10];

  initial begin
    sub_table = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,
      8'hab,8'h76,8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,
      8'h9c,8'ha4,8'h72,8'hc0,8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,
      8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
      8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,
      8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,8'h53,8'hd1,8'h00,8'hed,
      8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,8'hd0,8'hef,
      8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,
      8'hf3,8'hd2,8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,
      8'h64,8'h5d,8'h19,8'h73,8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,
      8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
      8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,
      8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,8'hba,8'h78,8'h25,8'h2e,
      8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,8'h70,8'h3e,
      8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,
      8'h28,8'hdf,8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,
      8'hb0,8'h54,8'hbb,8'h16
    };
    round_const = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};
  end

  // Multiply by x in GF(2^8), reducing by the AES polynomial.
  function automatic logic [7:0] gf_double(input logic [7:0] b);
    logic [8:0] v;
    v = {b, 1'b0};
    if (b[7]) v = v ^ 9'h11b;
    return v[7:0];
  endfunction

  // Full encryption of one block under the current key and round count.
  function automatic logic [127:0] encrypt_block(input logic [127:0] plain);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] rk [16];
    logic [7:0] w [4];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] key;
    logic [127:0] res;
    int nr;
    nr = rounds_q;
    // Round counts outside 1..10 saturate to the nearest legal value.
    if (nr < 1) nr = 1;
    if (nr > 10) nr = 10;
    key = {key_hi_q, key_lo_q};
    for (int i = 0; i < 16; i++) begin
      st[i] = plain[127 - 8*i -: 8] ^ key[127 - 8*i -: 8];
      rk[i] = key[127 - 8*i -: 8];
    end
    for (int r = 0; r < nr; r++) begin
      for (int i = 0; i < 4; i++) w[i] = sub_table[rk[12 + ((i + 1) % 4)]];
      w[0] = w[0] ^ round_const[r];
      for (int i = 0; i < 4; i++) rk[i] = rk[i] ^ w[i];
      for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
      // SubBytes and ShiftRows together: row r rotates left by r columns.
      for (int row = 0; row < 4; row++)
        for (int col = 0; col < 4; col++)
          tmp[row + 4*col] = sub_table[st[row + 4*((col + row) % 4)]];
      if (r + 1 < nr) begin
        for (int col = 0; col < 4; col++) begin
          a0 = tmp[4*col]; a1 = tmp[4*col+1]; a2 = tmp[4*col+2]; a3 = tmp[4*col+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          tmp[4*col]   = a0 ^ all ^ gf_double(a0 ^ a1);
          tmp[4*col+1] = a1 ^ all ^ gf_double(a1 ^ a2);
          tmp[4*col+2] = a2 ^ all ^ gf_double(a2 ^ a3);
          tmp[4*col+3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run watchdog: a hang anywhere ends the run as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("tb_aes128_block_encrypt NOT OK");
        $finish;
      end
    end
  end

  // Receiver stall pattern. A nonzero hold-off count forces a long stall;
  // otherwise the receiver stalls in bursts or not at all, chosen per span.
  initial begin
    int span;
    int pct;
    out_stall = 1'b1;
    hold_off_cycles = 0;
    @(negedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
        @(negedge clk);
      end else begin
        span = $urandom_range(5, 60);
        pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 70);
        for (int i = 0; i < span && hold_off_cycles == 0; i++) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(negedge clk);
        end
      end
    end
  end

  // Result checker: each output transfer is matched against the oldest
  // predicted ciphertext.
  initial begin
    logic [127:0] want;
    mismatches = 0;
    ciphers_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        ciphers_seen++;
        if (cipher_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected ciphertext %h %h", cipher_high, cipher_low);
        end else begin
          want = cipher_queue.pop_front();
          if (cipher_high !== want[127:64] || cipher_low !== want[63:0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Cipher mismatch: expected %h %h, got %h %h",
                       want[127:64], want[63:0], cipher_high, cipher_low);
          end
        end
      end
    end
  end

  // Sends one block; the prediction is queued at the accepting edge.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    in_valid   <= 1'b1;
    block_high <= hi;
    block_low  <= lo;
    do @(posedge clk); while (in_stall);
    cipher_queue.push_back(encrypt_block({hi, lo}));
    blocks_sent++;
    @(negedge clk);
  endtask

  // Between transfers the sender drops valid for a random gap, which may be
  // zero; while in a burst it usually skips the gap altogether.
  task automatic sender_gap();
    int gap;
    if (burst_mode && $urandom_range(0, 9) != 0) return;
    burst_mode = ($urandom_range(0, 2) == 0);
    gap = $urandom_range(0, 4);
    if (gap == 0) return;
    in_valid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  // One register write; valid drops for a cycle before the next write.
  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KEY_HIGH:    key_hi_q = value;
      CFG_KEY_LOW:     key_lo_q = value;
      CFG_ROUND_COUNT: rounds_q = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Lets the pipeline drain so configuration can change safely.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cipher_queue.size() != 0) @(negedge clk);
    repeat (PipeDepth + 2) @(negedge clk);
  endtask

  task automatic send_random(input int count);
    logic [63:0] hi, lo;
    for (int i = 0; i < count; i++) begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: hi = '0;
        1: lo = '1;
        default: ;
      endcase
      send_block(hi, lo);
      sender_gap();
    end
  endtask

  // Directed edges: zero and all-ones blocks and keys, the FIPS-197 test
  // vector, and the round counts that saturate.
  task automatic test_directed();
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    wait_drained();
    // FIPS-197 appendix vector at ten rounds.
    write_reg(CFG_KEY_HIGH, 64'h0001020304050607);
    write_reg(CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    wait_drained();
    // A round count of zero acts as one round.
    write_reg(CFG_ROUND_COUNT, 64'd0);
    send_block('1, '0);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    wait_drained();
    write_reg(CFG_ROUND_COUNT, 64'd1);
    send_block('0, '1);
    wait_drained();
    // Counts above ten act as ten.
    write_reg(CFG_ROUND_COUNT, 64'd15);
    send_block('1, '1);
    wait_drained();
    write_reg(CFG_ROUND_COUNT, 64'd11);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    wait_drained();
    // The spare index must leave every register alone.
    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_KEY_LOW, '1);
    send_block('0, '0);
    send_block('1, '1);
    wait_drained();
  endtask

  // Random keys and round counts, each followed by a run of random blocks.
  task automatic test_random_settings();
    for (int phase = 0; phase < 12; phase++) begin
      write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
      write_reg(CFG_KEY_LOW, {$urandom, $urandom});
      write_reg(CFG_ROUND_COUNT,
                (phase < 10) ? 64'(phase + 1) : 64'($urandom_range(0, 15)));
      send_random(40);
      wait_drained();
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall
  // its input, while the sender keeps offering blocks back to back.
  task automatic test_backpressure();
    write_reg(CFG_ROUND_COUNT, 64'd10);
    hold_off_cycles = 60;
    burst_mode = 1'b1;
    for (int i = 0; i < 40; i++) send_block({$urandom, $urandom}, {$urandom, $urandom});
    // The sender now pauses until every ciphertext has come back.
    wait_drained();
    send_random(80);
    wait_drained();
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    block_high = '0;
    block_low  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_KEY_HIGH;
    cfg_data   = '0;
    key_hi_q   = '0;
    key_lo_q   = '0;
    rounds_q   = 4'd10;
    blocks_sent = 0;
    burst_mode = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_settings();
    test_backpressure();

    wait_drained();
    $display("Sent %0d blocks and checked %0d ciphertexts over round counts 0 to 15,",
             blocks_sent, ciphers_seen);
    $display("with edge keys and blocks, random stalls and a full-pipeline hold-off.");
    if (mismatches == 0 && cipher_queue.size() == 0) begin
      $display("tb_aes128_block_encrypt OK");
    end else begin
      $display("%0d mismatches, %0d ciphertexts missing", mismatches, cipher_queue.size());
      $display("tb_aes128_block_encrypt NOT OK");
    end
    $finish;
  end

endmodule
